// ===== src/twrp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twrp_pkg
// Types and codes shared by the tiered weighted random pick unit and its
// port checker.
// ----------------------------------------------------------------------------
package twrp_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int TIER_COUNT_DEF  = 3;

   // fixed field widths of the item formats
   localparam int TIER_W   = 2;
   localparam int INWGT_W  = 16;
   localparam int RAND_W   = 32;
   localparam int CHIDX_W  = 6;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_DRAW   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_ZERO = 2'd2,
      ST_NONE = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type              command;
      logic [TIER_W-1:0]    entry_tier;
      logic [INWGT_W-1:0]   entry_weight;
      logic [TIER_W-1:0]    draw_tier;
      logic [RAND_W-1:0]    random_value;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [CHIDX_W-1:0]   chosen_index;
      logic [TIER_W-1:0]    chosen_tier;
   } rsp_type;

endpackage
`default_nettype wire

// ===== src/tiered_weighted_random_pick_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tiered_weighted_random_pick_unit
// Weighted random pick from a table of tiered entries.
// ----------------------------------------------------------------------------
// Clear and append are carried out when accepted, and their result shows in
// the output register on the next cycle. A draw runs per tier tried: a summing
// pass over the table, then for the first tier that holds entries a bit-serial
// reduction of the 32-bit random word, a step to form r, and a selecting pass,
// plus a final step that posts the result. With a full table of 64 entries each
// empty tier skipped adds another summing pass over all of them. The pace is set
// by the single read port of the entry memory, one entry per cycle, and by the
// one shared add/subtract unit that does the summing, the reduction and the walk.
// A new item is taken only while the sequencer is idle and the output
// register is free or being emptied.
// ----------------------------------------------------------------------------
module tiered_weighted_random_pick_unit #(
   parameter int MAX_ENTRIES = twrp_pkg::MAX_ENTRIES_DEF,
   parameter int WEIGHT_BITS = twrp_pkg::WEIGHT_BITS_DEF,
   parameter int TIER_COUNT  = twrp_pkg::TIER_COUNT_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire twrp_pkg::req_type req_item,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      twrp_pkg::rsp_type rsp_item
);

   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int SUM_W  = WEIGHT_BITS + CNT_W;
   localparam int ACC_W  = SUM_W + 1;
   localparam int ALU_W  = ACC_W + 1;
   localparam int ENT_W  = twrp_pkg::TIER_W + WEIGHT_BITS;
   localparam int BIT_W  = $clog2(twrp_pkg::RAND_W);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SUM  = 6'b000010,
      S_MOD  = 6'b000100,
      S_INC  = 6'b001000,
      S_SEL  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   // entry memory
   logic [ENT_W-1:0] mem [MAX_ENTRIES];

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            addr_ff, addr_in;
   logic                        rd_vld_ff;
   logic [ENT_W-1:0]            rd_data_ff;
   logic [IDX_W-1:0]            rd_idx_ff;
   logic [twrp_pkg::TIER_W-1:0] tier_ff, tier_in;
   logic [ACC_W-1:0]            acc_ff, acc_in;
   logic [SUM_W-1:0]            total_ff, total_in;
   logic [twrp_pkg::RAND_W-1:0] rv_ff, rv_in;
   logic [BIT_W-1:0]            bit_ff, bit_in;
   twrp_pkg::rsp_type           res_ff, res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   twrp_pkg::rsp_type           rsp_item_ff, rsp_item_in;

   logic                        accept;
   logic                        rsp_free;
   logic                        rd_en;
   logic                        wr_en;
   logic [WEIGHT_BITS-1:0]      w_in;
   logic [twrp_pkg::TIER_W-1:0] etier_clamped;
   logic [twrp_pkg::TIER_W-1:0] dtier_clamped;
   logic [twrp_pkg::TIER_W-1:0] rd_tier;
   logic [WEIGHT_BITS-1:0]      rd_wgt;
   logic                        match;
   logic                        scan_end;
   logic [ACC_W-1:0]            rem_shift;
   logic [ALU_W-1:0]            alu_a, alu_b, alu_res;
   logic                        alu_sub;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && rsp_free);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign w_in     = WEIGHT_BITS'(req_item.entry_weight);
   assign rd_tier  = rd_data_ff[ENT_W-1 -: twrp_pkg::TIER_W];
   assign rd_wgt   = rd_data_ff[WEIGHT_BITS-1:0];
   assign match    = rd_vld_ff && (rd_tier == tier_ff);
   assign scan_end = (addr_ff == count_ff) && !rd_vld_ff;
   assign rd_en    = ((state_ff == S_SUM) || (state_ff == S_SEL)) && (addr_ff < count_ff);
   assign wr_en    = accept && (req_item.command == twrp_pkg::CMD_APPEND) &&
                     (count_ff < CNT_W'(MAX_ENTRIES)) && (w_in != '0);
   assign rem_shift = {acc_ff[ACC_W-2:0], rv_ff[twrp_pkg::RAND_W-1]};

   // tiers above the top one saturate
   always_comb begin
      if (32'(req_item.entry_tier) > TIER_COUNT - 1) begin
         etier_clamped = twrp_pkg::TIER_W'(TIER_COUNT - 1);
      end else begin
         etier_clamped = req_item.entry_tier;
      end
      if (32'(req_item.draw_tier) > TIER_COUNT - 1) begin
         dtier_clamped = twrp_pkg::TIER_W'(TIER_COUNT - 1);
      end else begin
         dtier_clamped = req_item.draw_tier;
      end
   end

   // shared add/subtract unit
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         S_SUM: begin
            alu_a = ALU_W'(acc_ff);
            alu_b = ALU_W'(rd_wgt);
         end
         S_MOD: begin
            alu_a   = ALU_W'(rem_shift);
            alu_b   = ALU_W'(total_ff);
            alu_sub = 1'b1;
         end
         S_INC: begin
            alu_a = ALU_W'(acc_ff);
            alu_b = ALU_W'(1);
         end
         S_SEL: begin
            alu_a   = ALU_W'(acc_ff);
            alu_b   = ALU_W'(rd_wgt);
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
      alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      tier_in      = tier_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      rv_in        = rv_ff;
      bit_in       = bit_ff;
      res_in       = res_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (rd_en) begin
         addr_in = addr_ff + 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_item_in.status       = twrp_pkg::ST_OK;
               rsp_item_in.chosen_index = '0;
               rsp_item_in.chosen_tier  = '0;
               case (req_item.command)
                  twrp_pkg::CMD_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  twrp_pkg::CMD_APPEND: begin
                     if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
                        rsp_item_in.status = twrp_pkg::ST_FULL;
                     end else if (w_in == '0) begin
                        rsp_item_in.status = twrp_pkg::ST_ZERO;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  twrp_pkg::CMD_DRAW: begin
                     tier_in  = dtier_clamped;
                     rv_in    = req_item.random_value;
                     acc_in   = '0;
                     addr_in  = '0;
                     state_in = S_SUM;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SUM: begin
            if (match) begin
               acc_in = alu_res[ACC_W-1:0];
            end
            if (scan_end) begin
               if (acc_ff == '0) begin
                  // tier empty: fall back or give up
                  if (tier_ff == '0) begin
                     res_in.status       = twrp_pkg::ST_NONE;
                     res_in.chosen_index = '0;
                     res_in.chosen_tier  = '0;
                     state_in            = S_DONE;
                  end else begin
                     tier_in  = tier_ff - 1'b1;
                     acc_in   = '0;
                     addr_in  = '0;
                  end
               end else begin
                  total_in = acc_ff[SUM_W-1:0];
                  acc_in   = '0;
                  bit_in   = BIT_W'(twrp_pkg::RAND_W - 1);
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            // restoring remainder, one bit of the random word per cycle
            if (alu_res[ALU_W-1]) begin
               acc_in = rem_shift;
            end else begin
               acc_in = alu_res[ACC_W-1:0];
            end
            rv_in  = rv_ff << 1;
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = S_INC;
            end
         end
         S_INC: begin
            acc_in   = alu_res[ACC_W-1:0];
            addr_in  = '0;
            state_in = S_SEL;
         end
         S_SEL: begin
            if (match && (alu_res[ALU_W-1] || (alu_res == '0))) begin
               // weight covers what is left of r
               res_in.status       = twrp_pkg::ST_OK;
               res_in.chosen_index = twrp_pkg::CHIDX_W'(rd_idx_ff);
               res_in.chosen_tier  = tier_ff;
               state_in            = S_DONE;
            end else if (match) begin
               acc_in = alu_res[ACC_W-1:0];
            end else if (scan_end) begin
               if (tier_ff == '0) begin
                  res_in.status       = twrp_pkg::ST_NONE;
                  res_in.chosen_index = '0;
                  res_in.chosen_tier  = '0;
                  state_in            = S_DONE;
               end else begin
                  tier_in  = tier_ff - 1'b1;
                  acc_in   = '0;
                  addr_in  = '0;
                  state_in = S_SUM;
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_item_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= {etier_clamped, w_in};
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr_ff[IDX_W-1:0]];
         rd_idx_ff  <= addr_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff     <= addr_in;
      tier_ff     <= tier_in;
      acc_ff      <= acc_in;
      total_ff    <= total_in;
      rv_ff       <= rv_in;
      bit_ff      <= bit_in;
      res_ff      <= res_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule
`default_nettype wire

// ===== src/twrp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twrp_checker
// Port-level checks for the tiered weighted random pick unit.
// ----------------------------------------------------------------------------
module twrp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire twrp_pkg::req_type req_item,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire twrp_pkg::rsp_type rsp_item
);

   logic req_acc;

   assign req_acc = req_valid && !req_stall;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // a clear answers on the very next cycle
   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_item.command == twrp_pkg::CMD_CLEAR) |=>
         rsp_valid && (rsp_item.status == twrp_pkg::ST_OK) &&
         (rsp_item.chosen_index == '0))
      else $error("clear item not answered at once");

   // a draw keeps the input side closed while it runs
   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_item.command == twrp_pkg::CMD_DRAW) |=> req_stall)
      else $error("input taken during a draw");

   // any failing status carries no pick
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != twrp_pkg::ST_OK) |->
         (rsp_item.chosen_index == '0) && (rsp_item.chosen_tier == '0))
      else $error("failing result carries a pick");

endmodule

bind tiered_weighted_random_pick_unit twrp_checker u_twrp_checker (.*);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tiered weighted random pick unit. A local
// model of the entry table predicts status, index and tier for every
// accepted command; results are matched in order against those predictions
// under random idle and stall on both channels.
// ----------------------------------------------------------------------------
module tb;

   localparam int TABLE_DEPTH = twrp_pkg::MAX_ENTRIES_DEF;
   localparam int TOP_TIER    = twrp_pkg::TIER_COUNT_DEF - 1;
   localparam int TIER_W      = twrp_pkg::TIER_W;
   localparam int INWGT_W     = twrp_pkg::INWGT_W;
   localparam int RAND_W      = twrp_pkg::RAND_W;
   localparam int CHIDX_W     = twrp_pkg::CHIDX_W;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int MAX_REPORTS = 10;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   twrp_pkg::req_type req_item  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   twrp_pkg::rsp_type rsp_item;

   tiered_weighted_random_pick_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #6 clock = ~clock;

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int hold_left       = 0;
   int error_count     = 0;

   // predicted picks, oldest first
   twrp_pkg::rsp_type awaited_picks[$];

   // local copy of the entry table
   logic [TIER_W-1:0]  tbl_tier[TABLE_DEPTH];
   logic [INWGT_W-1:0] tbl_weight[TABLE_DEPTH];
   int                 tbl_count = 0;

   function automatic logic [TIER_W-1:0] saturate_tier(logic [TIER_W-1:0] t);
      return (t > TOP_TIER) ? TIER_W'(TOP_TIER) : t;
   endfunction

   // applies one command to the local table and returns the pick it gives
   function automatic twrp_pkg::rsp_type pick_outcome(twrp_pkg::req_type item);
      twrp_pkg::rsp_type o;
      longint unsigned   total;
      longint unsigned   r;
      int                t;
      int                i;
      bit                found;
      o = '0;
      o.status = twrp_pkg::ST_OK;
      found = 1'b0;
      if (item.command == twrp_pkg::CMD_CLEAR) begin
         tbl_count = 0;
      end else if (item.command == twrp_pkg::CMD_APPEND) begin
         if (tbl_count >= TABLE_DEPTH) begin
            o.status = twrp_pkg::ST_FULL;
         end else if (item.entry_weight == '0) begin
            o.status = twrp_pkg::ST_ZERO;
         end else begin
            tbl_tier[tbl_count]   = saturate_tier(item.entry_tier);
            tbl_weight[tbl_count] = item.entry_weight;
            tbl_count++;
         end
      end else if (item.command == twrp_pkg::CMD_DRAW) begin
         o.status = twrp_pkg::ST_NONE;
         for (t = int'(saturate_tier(item.draw_tier)); t >= 0 && !found; t--) begin
            total = 0;
            for (i = 0; i < tbl_count; i++)
               if (tbl_tier[i] == t) total += tbl_weight[i];
            if (total != 0) begin
               r = (longint'(item.random_value) % total) + 1;
               for (i = 0; i < tbl_count && !found; i++) begin
                  if (tbl_tier[i] == t) begin
                     if (tbl_weight[i] >= r) begin
                        found          = 1'b1;
                        o.status       = twrp_pkg::ST_OK;
                        o.chosen_index = CHIDX_W'(i);
                        o.chosen_tier  = TIER_W'(t);
                     end else begin
                        r -= tbl_weight[i];
                     end
                  end
               end
            end
         end
      end
      return o;
   endfunction

   function automatic twrp_pkg::req_type make_item(logic [1:0] cmd, int etier, int wgt,
                                                   int dtier, logic [RAND_W-1:0] rnd);
      twrp_pkg::req_type item;
      item.command      = twrp_pkg::cmd_type'(cmd);
      item.entry_tier   = TIER_W'(etier);
      item.entry_weight = INWGT_W'(wgt);
      item.draw_tier    = TIER_W'(dtier);
      item.random_value = rnd;
      return item;
   endfunction

   function automatic twrp_pkg::req_type random_item(int clear_pct);
      twrp_pkg::req_type item;
      int                sel;
      item.entry_tier = TIER_W'($urandom_range(3));
      item.draw_tier  = TIER_W'($urandom_range(3));
      case ($urandom_range(9))
         0:       item.entry_weight = '0;
         1:       item.entry_weight = '1;
         2, 3:    item.entry_weight = INWGT_W'($urandom_range(1, 15));
         default: item.entry_weight = INWGT_W'($urandom);
      endcase
      case ($urandom_range(7))
         0:       item.random_value = '0;
         1:       item.random_value = '1;
         default: item.random_value = RAND_W'($urandom);
      endcase
      sel = $urandom_range(99);
      if (sel < clear_pct)          item.command = twrp_pkg::CMD_CLEAR;
      else if (sel < clear_pct + 2) item.command = twrp_pkg::cmd_type'(CMD_UNUSED);
      else if (sel < 52)            item.command = twrp_pkg::CMD_APPEND;
      else                          item.command = twrp_pkg::CMD_DRAW;
      return item;
   endfunction

   // called at a rising edge; returns at the edge that took the item, or later after a random idle gap
   task automatic send_item(twrp_pkg::req_type item);
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_picks = {awaited_picks, pick_outcome(item)};
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_picks.size() != 0) @(posedge clock);
   endtask

   task automatic note_error(string what, bit has_want, twrp_pkg::rsp_type want,
                             twrp_pkg::rsp_type got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         if (has_want)
            $display("%0t %s: expected status %s index %0d tier %0d, got %s %0d %0d",
                     $realtime, what, want.status.name(), want.chosen_index,
                     want.chosen_tier, got.status.name(), got.chosen_index,
                     got.chosen_tier);
         else
            $display("%0t %s: got status %s index %0d tier %0d", $realtime, what,
                     got.status.name(), got.chosen_index, got.chosen_tier);
      end
   endtask

   // receiver: long hold-off when asked, else random stall
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      twrp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_picks.size() == 0) begin
            note_error("unexpected item", 1'b0, '0, rsp_item);
         end else begin
            want = awaited_picks.pop_front();
            if (rsp_item.status !== want.status ||
                rsp_item.chosen_index !== want.chosen_index ||
                rsp_item.chosen_tier !== want.chosen_tier)
               note_error("mismatch", 1'b1, want, rsp_item);
         end
      end
   end

   task automatic test_empty_table();
      send_item(make_item(twrp_pkg::CMD_DRAW, 0, 0, 3, '0));
      send_item(make_item(twrp_pkg::CMD_APPEND, 1, 0, 0, '0));
      send_item(make_item(CMD_UNUSED, 3, 16'hFFFF, 3, '1));
      send_item(make_item(twrp_pkg::CMD_CLEAR, 0, 0, 0, '0));
   endtask

   task automatic test_append_draw();
      send_item(make_item(twrp_pkg::CMD_APPEND, 0, 1, 0, '0));
      send_item(make_item(twrp_pkg::CMD_APPEND, 1, 16'hFFFF, 0, '0));
      // tier 3 saturates to the top tier
      send_item(make_item(twrp_pkg::CMD_APPEND, 3, 16'h8000, 0, '0));
      send_item(make_item(twrp_pkg::CMD_APPEND, 1, 2, 0, '0));
      send_item(make_item(twrp_pkg::CMD_DRAW, 0, 0, 0, '1));
      send_item(make_item(twrp_pkg::CMD_DRAW, 0, 0, 1, '0));
      // walk runs past the heavy entry onto the light one
      send_item(make_item(twrp_pkg::CMD_DRAW, 0, 0, 1, 32'h0000_FFFF));
      send_item(make_item(twrp_pkg::CMD_DRAW, 0, 0, 2, '1));
      send_item(make_item(twrp_pkg::CMD_DRAW, 0, 0, 3, 32'd5));
      send_item(make_item(CMD_UNUSED, 0, 0, 0, '0));
   endtask

   task automatic test_tier_fallback();
      send_item(make_item(twrp_pkg::CMD_CLEAR, 0, 0, 0, '0));
      send_item(make_item(twrp_pkg::CMD_APPEND, 0, 3, 0, '0));
      send_item(make_item(twrp_pkg::CMD_DRAW, 0, 0, 2, 32'hDEAD_BEEF));
      send_item(make_item(twrp_pkg::CMD_DRAW, 0, 0, 1, 32'd2));
   endtask

   task automatic test_table_full();
      int i;
      send_item(make_item(twrp_pkg::CMD_CLEAR, 0, 0, 0, '0));
      for (i = 0; i < TABLE_DEPTH; i++)
         send_item(make_item(twrp_pkg::CMD_APPEND, 0, 1, 0, '0));
      // full is reported ahead of zero weight
      send_item(make_item(twrp_pkg::CMD_APPEND, 0, 0, 0, '0));
      send_item(make_item(twrp_pkg::CMD_APPEND, 2, 5, 0, '0));
      send_item(make_item(twrp_pkg::CMD_DRAW, 0, 0, 0, 32'd63));
      send_item(make_item(twrp_pkg::CMD_DRAW, 0, 0, 2, '1));
      send_item(make_item(twrp_pkg::CMD_CLEAR, 0, 0, 0, '0));
   endtask

   task automatic test_backpressure();
      int i;
      sender_idle_pct = 0;
      stall_pct       = 0;
      hold_left       = 400;
      for (i = 0; i < 30; i++) send_item(random_item(3));
      wait_drained();
   endtask

   task automatic test_random_traffic(int count, int idle_pct, int rx_pct,
                                      int clear_pct);
      int i;
      sender_idle_pct = idle_pct;
      stall_pct       = rx_pct;
      for (i = 0; i < count; i++) send_item(random_item(clear_pct));
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_append_draw();
      test_tier_fallback();
      test_table_full();
      wait_drained();
      test_backpressure();
      test_random_traffic(440, 0, 0, 2);
      test_random_traffic(440, 46, 0, 1);
      test_random_traffic(440, 0, 46, 3);
      test_random_traffic(440, 28, 28, 2);
      wait_drained();
      repeat (400) @(posedge clock);
      if (error_count == 0) begin
         $display("** tiered_weighted_random_pick_unit: PASSED **");
      end else begin
         $display("** tiered_weighted_random_pick_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #(40_000_000);
      $display("** tiered_weighted_random_pick_unit: FAILED **");
      $finish;
   end

endmodule

// ===== tiered_weighted_random_pick_unit.f =====
src/twrp_pkg.sv
src/tiered_weighted_random_pick_unit.sv
src/twrp_checker.sv
tb/tb.sv
